>>> design/ldp_pkg.sv
// ldp_pkg: types, constants and saturation helpers for lens_distort_and_project.
// Shared by ldp_qmul and the top level; depends on nothing.
package ldp_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int INT_W      = 48;
    localparam int DIV_STAGES = 47;
    localparam int SIDE_DEPTH = 24;
    localparam int NUM_MUL    = 14;

    typedef logic signed [INT_W-1:0] int_t;
    typedef logic signed [INT_W+1:0] wide_t;

    localparam int_t INT_LIM = int_t'((64'sd1 <<< 47) - 64'sd1);
    localparam int_t QONE    = int_t'(64'sd1 <<< FRAC_BITS);

    // register indexes of the configuration port
    localparam logic [2:0] REG_COEFF_0   = 3'd0;
    localparam logic [2:0] REG_COEFF_1   = 3'd1;
    localparam logic [2:0] REG_COEFF_2   = 3'd2;
    localparam logic [2:0] REG_COEFF_3   = 3'd3;
    localparam logic [2:0] REG_COEFF_4   = 3'd4;
    localparam logic [2:0] REG_FOCAL_X   = 3'd5;
    localparam logic [2:0] REG_FOCAL_Y   = 3'd6;
    localparam logic [2:0] REG_PRINCIPAL = 3'd7;

    localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

    // divider stage contents
    typedef struct packed {
        logic        valid;
        logic        inv;
        logic        neg_x;
        logic        neg_y;
        logic        ovf_x;
        logic        ovf_y;
        logic [30:0] z;
        logic [30:0] rem_x;
        logic [30:0] rem_y;
        logic [46:0] dvd_x;
        logic [46:0] dvd_y;
        logic [46:0] quo_x;
        logic [46:0] quo_y;
    } div_t;

    // values carried along the multiply section
    typedef struct packed {
        logic valid;
        logic inv;
        int_t nx;
        int_t ny;
        int_t x2;
        int_t y2;
        int_t r2;
        int_t xy2;
        int_t rx;
        int_t ry;
        int_t t;
        int_t ux;
        int_t uy;
    } side_t;

    function automatic int_t clamp_int(input wide_t v);
        wide_t lim;
        lim = wide_t'(INT_LIM);
        if (v > lim) begin
            return INT_LIM;
        end else if (v < -lim) begin
            return -INT_LIM;
        end
        return int_t'(v);
    endfunction

    function automatic logic [31:0] sat32(input wide_t v);
        if (v > wide_t'(32'sh7fff_ffff)) begin
            return 32'h7fff_ffff;
        end else if (v < wide_t'(-33'sh0_8000_0000)) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> design/ldp_qmul.sv
// ldp_qmul: three-stage signed Q.28 multiply, magnitude truncated, saturated.
// Depends on ldp_pkg.
module ldp_qmul (
    input  logic          aclk,
    input  logic          ce,
    input  ldp_pkg::int_t a,
    input  ldp_pkg::int_t b,
    output ldp_pkg::int_t p
);
    import ldp_pkg::*;

    logic [47:0] ma, mb;
    logic        neg_s1_reg, neg_s2_reg;
    logic [47:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [95:0] prod_next, prod_reg;
    logic [67:0] shifted;
    logic [46:0] mag;
    int_t        p_next, p_reg;

    always_comb begin
        ma = a[47] ? 48'(-a) : 48'(a);
        mb = b[47] ? 48'(-b) : 48'(b);
    end

    // stage 1: four 24x24 partial products
    always_ff @(posedge aclk) begin
        if (ce) begin
            neg_s1_reg <= a[47] ^ b[47];
            ll_reg     <= 48'(ma[23:0])  * 48'(mb[23:0]);
            lh_reg     <= 48'(ma[23:0])  * 48'(mb[47:24]);
            hl_reg     <= 48'(ma[47:24]) * 48'(mb[23:0]);
            hh_reg     <= 48'(ma[47:24]) * 48'(mb[47:24]);
        end
    end

    // stage 2: full product
    assign prod_next = ({48'd0, hh_reg} << 48) + ({48'd0, lh_reg} << 24)
                     + ({48'd0, hl_reg} << 24) + {48'd0, ll_reg};

    always_ff @(posedge aclk) begin
        if (ce) begin
            neg_s2_reg <= neg_s1_reg;
            prod_reg   <= prod_next;
        end
    end

    // stage 3: back to Q.28, saturate, sign
    always_comb begin
        shifted = prod_reg[95:FRAC_BITS];
        mag     = (|shifted[67:47]) ? INT_LIM[46:0] : shifted[46:0];
        p_next  = neg_s2_reg ? -int_t'({1'b0, mag}) : int_t'({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> design/lens_distort_and_project.sv
// lens_distort_and_project: x/z, y/z, Brown-Conrady distortion, pinhole projection.
// Depends on ldp_pkg and ldp_qmul.
//
//  channel | ports                       | payload
//  --------+-----------------------------+----------------------------------------
//  input   | s_tvalid s_tready s_tdata   | point_x, point_y, point_z (Q16.16)
//  output  | m_tvalid m_tready m_tdata   | pixel_u, pixel_v (Q16.16); m_tuser invalid
//  config  | cfg_wr_en cfg_index cfg_wdata | registers 0..7, write only
//
// One transaction per cycle sustained while the output is not stalled. Pipeline:
// one input stage, 47 restoring-divider stages (one quotient bit each), 24 stages
// of multiply and add (six three-stage multiplier rounds), one output register.
// aresetn (synchronous) clears the valid bits and resets the configuration registers.
// A stall on the output freezes the whole pipeline; s_tready is low only while a
// result sits in the output register and m_tready is low.
module lens_distort_and_project (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_u [31:0], pixel_v [63:32]
    output logic        m_tuser,   // invalid [0]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import ldp_pkg::*;

    // ---------------- configuration ----------------
    logic signed [31:0] coeff_reg [5];
    logic [31:0]        focal_x_reg, focal_y_reg;
    logic [63:0]        principal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                coeff_reg[i] <= '0;
            end
            focal_x_reg   <= FOCAL_RESET;
            focal_y_reg   <= FOCAL_RESET;
            principal_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEFF_0:   coeff_reg[0]  <= cfg_wdata[31:0];
                REG_COEFF_1:   coeff_reg[1]  <= cfg_wdata[31:0];
                REG_COEFF_2:   coeff_reg[2]  <= cfg_wdata[31:0];
                REG_COEFF_3:   coeff_reg[3]  <= cfg_wdata[31:0];
                REG_COEFF_4:   coeff_reg[4]  <= cfg_wdata[31:0];
                REG_FOCAL_X:   focal_x_reg   <= cfg_wdata[31:0];
                REG_FOCAL_Y:   focal_y_reg   <= cfg_wdata[31:0];
                REG_PRINCIPAL: principal_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // five-term mode when k3 register is nonzero; three-term drops the tangential terms
    logic five_term;
    int_t k_cubic, k_p1, k_p2;
    always_comb begin
        five_term = (coeff_reg[4] != '0);
        k_cubic   = five_term ? int_t'(coeff_reg[4]) : int_t'(coeff_reg[2]);
        k_p1      = five_term ? int_t'(coeff_reg[2]) : '0;
        k_p2      = five_term ? int_t'(coeff_reg[3]) : '0;
    end

    // ---------------- pipeline enable ----------------
    logic m_valid_reg;
    logic ce;
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // ---------------- input stage: magnitudes, depth check ----------------
    logic        e_valid_reg, e_inv_reg, e_negx_reg, e_negy_reg;
    logic [31:0] e_ax_reg, e_ay_reg;
    logic [30:0] e_z_reg;
    logic [31:0] in_x, in_y, in_z;
    logic        in_inv;

    always_comb begin
        in_x   = s_tdata[31:0];
        in_y   = s_tdata[63:32];
        in_z   = s_tdata[95:64];
        in_inv = in_z[31] || (in_z == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (ce) begin
            e_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_inv_reg  <= in_inv;
            e_negx_reg <= in_x[31];
            e_negy_reg <= in_y[31];
            e_ax_reg   <= in_x[31] ? -in_x : in_x;
            e_ay_reg   <= in_y[31] ? -in_y : in_y;
            e_z_reg    <= in_inv ? 31'd1 : in_z[30:0];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    div_t div_reg  [DIV_STAGES];
    div_t div_next [DIV_STAGES];

    always_comb begin
        div_t        cur;
        logic [31:0] sx, sy;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                cur.valid = e_valid_reg;
                cur.inv   = e_inv_reg;
                cur.neg_x = e_negx_reg;
                cur.neg_y = e_negy_reg;
                // quotient reaches 2^47 exactly when |x| >= z * 2^19
                cur.ovf_x = {18'd0, e_ax_reg} >= {e_z_reg, 19'd0};
                cur.ovf_y = {18'd0, e_ay_reg} >= {e_z_reg, 19'd0};
                cur.z     = e_z_reg;
                cur.rem_x = {18'd0, e_ax_reg[31:19]};
                cur.rem_y = {18'd0, e_ay_reg[31:19]};
                cur.dvd_x = {e_ax_reg[18:0], 28'd0};
                cur.dvd_y = {e_ay_reg[18:0], 28'd0};
                cur.quo_x = '0;
                cur.quo_y = '0;
            end else begin
                cur = div_reg[k-1];
            end
            sx = {cur.rem_x, cur.dvd_x[46]};
            sy = {cur.rem_y, cur.dvd_y[46]};
            div_next[k] = cur;
            div_next[k].dvd_x = {cur.dvd_x[45:0], 1'b0};
            div_next[k].dvd_y = {cur.dvd_y[45:0], 1'b0};
            if (sx >= {1'b0, cur.z}) begin
                div_next[k].rem_x = 31'(sx - {1'b0, cur.z});
                div_next[k].quo_x = {cur.quo_x[45:0], 1'b1};
            end else begin
                div_next[k].rem_x = sx[30:0];
                div_next[k].quo_x = {cur.quo_x[45:0], 1'b0};
            end
            if (sy >= {1'b0, cur.z}) begin
                div_next[k].rem_y = 31'(sy - {1'b0, cur.z});
                div_next[k].quo_y = {cur.quo_y[45:0], 1'b1};
            end else begin
                div_next[k].rem_y = sy[30:0];
                div_next[k].quo_y = {cur.quo_y[45:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!aresetn) begin
                div_reg[k].valid <= 1'b0;
            end else if (ce) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ---------------- multiply section ----------------
    // Multiplier rounds read stage 0, 4, 8, 12, 16, 20; results meet the side
    // data three stages later.
    side_t sd_reg  [SIDE_DEPTH];
    side_t sd_next [SIDE_DEPTH];
    int_t  qa [NUM_MUL];
    int_t  qb [NUM_MUL];
    int_t  qp [NUM_MUL];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_MUL; gi++) begin : g_mul
            ldp_qmul u_qmul (
                .aclk (aclk),
                .ce   (ce),
                .a    (qa[gi]),
                .b    (qb[gi]),
                .p    (qp[gi])
            );
        end
    endgenerate

    always_comb begin
        // x^2, y^2, x*y
        qa[0]  = sd_reg[0].nx;   qb[0]  = sd_reg[0].nx;
        qa[1]  = sd_reg[0].ny;   qb[1]  = sd_reg[0].ny;
        qa[2]  = sd_reg[0].nx;   qb[2]  = sd_reg[0].ny;
        // radial polynomial, Horner form
        qa[3]  = k_cubic;        qb[3]  = sd_reg[4].r2;
        qa[4]  = sd_reg[8].t;    qb[4]  = sd_reg[8].r2;
        qa[5]  = sd_reg[12].t;   qb[5]  = sd_reg[12].r2;
        // radial scale plus tangential terms
        qa[6]  = sd_reg[16].nx;  qb[6]  = sd_reg[16].t;
        qa[7]  = k_p1;           qb[7]  = sd_reg[16].xy2;
        qa[8]  = k_p2;           qb[8]  = sd_reg[16].rx;
        qa[9]  = sd_reg[16].ny;  qb[9]  = sd_reg[16].t;
        qa[10] = k_p1;           qb[10] = sd_reg[16].ry;
        qa[11] = k_p2;           qb[11] = sd_reg[16].xy2;
        // focal lengths
        qa[12] = sd_reg[20].ux;  qb[12] = int_t'({16'd0, focal_x_reg});
        qa[13] = sd_reg[20].uy;  qb[13] = int_t'({16'd0, focal_y_reg});
    end

    always_comb begin
        div_t        dl;
        logic [47:0] mag_x, mag_y;
        dl    = div_reg[DIV_STAGES-1];
        mag_x = dl.ovf_x ? 48'(INT_LIM) : {1'b0, dl.quo_x};
        mag_y = dl.ovf_y ? 48'(INT_LIM) : {1'b0, dl.quo_y};

        sd_next[0]       = '0;
        sd_next[0].valid = dl.valid;
        sd_next[0].inv   = dl.inv;
        sd_next[0].nx    = dl.neg_x ? -int_t'(mag_x) : int_t'(mag_x);
        sd_next[0].ny    = dl.neg_y ? -int_t'(mag_y) : int_t'(mag_y);
        for (int i = 1; i < SIDE_DEPTH; i++) begin
            sd_next[i] = sd_reg[i-1];
        end

        sd_next[4].x2  = qp[0];
        sd_next[4].y2  = qp[1];
        sd_next[4].r2  = clamp_int(wide_t'(qp[0]) + wide_t'(qp[1]));
        sd_next[4].xy2 = clamp_int(wide_t'(qp[2]) + wide_t'(qp[2]));

        sd_next[5].rx  = clamp_int(wide_t'(sd_reg[4].r2) + wide_t'(sd_reg[4].x2)
                                   + wide_t'(sd_reg[4].x2));
        sd_next[5].ry  = clamp_int(wide_t'(sd_reg[4].r2) + wide_t'(sd_reg[4].y2)
                                   + wide_t'(sd_reg[4].y2));

        sd_next[8].t   = clamp_int(wide_t'(qp[3]) + wide_t'(coeff_reg[1]));
        sd_next[12].t  = clamp_int(wide_t'(qp[4]) + wide_t'(coeff_reg[0]));
        sd_next[16].t  = clamp_int(wide_t'(QONE) + wide_t'(qp[5]));

        sd_next[20].ux = clamp_int(wide_t'(qp[6]) + wide_t'(qp[7]) + wide_t'(qp[8]));
        sd_next[20].uy = clamp_int(wide_t'(qp[9]) + wide_t'(qp[10]) + wide_t'(qp[11]));
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SIDE_DEPTH; i++) begin
            if (!aresetn) begin
                sd_reg[i].valid <= 1'b0;
            end else if (ce) begin
                sd_reg[i] <= sd_next[i];
            end
        end
    end

    // ---------------- output register ----------------
    logic [31:0] u_next, v_next, u_reg, v_reg;
    logic        inv_reg;

    always_comb begin
        u_next = sat32(wide_t'(qp[12]) + wide_t'({18'd0, principal_reg[63:32]}));
        v_next = sat32(wide_t'(qp[13]) + wide_t'({18'd0, principal_reg[31:0]}));
        if (sd_reg[SIDE_DEPTH-1].inv) begin
            u_next = '0;
            v_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= sd_reg[SIDE_DEPTH-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            inv_reg <= sd_reg[SIDE_DEPTH-1].inv;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {v_reg, u_reg};
    assign m_tuser  = inv_reg;

    // ---------------- assertions ----------------
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid point with nonzero coordinates");

    a_back_pressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(sd_reg[SIDE_DEPTH-1].valid) && $stable(div_reg[0].valid))
        else $error("pipeline moved during stall");

    a_nx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sd_reg[0].valid |-> sd_reg[0].nx <= INT_LIM && sd_reg[0].nx >= -INT_LIM)
        else $error("normalized x beyond internal limit");

endmodule

>>> tb/lens_distort_and_project_checker.sv
// Checker for lens_distort_and_project: watches config writes and both streams,
// predicts pixel coordinates in fixed point and compares in order. Uses ldp_pkg.
module lens_distort_and_project_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import ldp_pkg::*;

    localparam longint LIM = (64'sd1 <<< 47) - 1;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        inv;
    } pixel_t;

    logic [63:0] coeff_regs [8];
    pixel_t      pixel_queue [$];

    assign pending = pixel_queue.size();

    function automatic longint clip47(input longint v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    // magnitude product >> 28, truncated, saturated, signed
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        logic         neg;
        longint       r;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = p >> 28;
        r = (p > 128'(LIM)) ? LIM : longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic longint sat_32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic pixel_t project_point(input logic [95:0] d);
        longint x, y, z, k1, k2, c2, c3, c4, nx, ny, x2, y2, r2, kr, t, ux, uy, xy2;
        pixel_t p;
        x = longint'($signed(d[31:0]));
        y = longint'($signed(d[63:32]));
        z = longint'($signed(d[95:64]));
        p = '0;
        if (z <= 0) begin
            p.inv = 1'b1;
            return p;
        end
        k1 = longint'($signed(coeff_regs[0][31:0]));
        k2 = longint'($signed(coeff_regs[1][31:0]));
        c2 = longint'($signed(coeff_regs[2][31:0]));
        c3 = longint'($signed(coeff_regs[3][31:0]));
        c4 = longint'($signed(coeff_regs[4][31:0]));
        nx = clip47((x * (64'sd1 <<< 28)) / z);
        ny = clip47((y * (64'sd1 <<< 28)) / z);
        x2 = fx_mul(nx, nx);
        y2 = fx_mul(ny, ny);
        r2 = clip47(x2 + y2);
        if (c4 != 0) begin
            xy2 = clip47(2 * fx_mul(nx, ny));
            t = clip47(fx_mul(c4, r2) + k2);
            t = clip47(fx_mul(t, r2) + k1);
            kr = clip47((64'sd1 <<< 28) + fx_mul(t, r2));
            ux = clip47(fx_mul(nx, kr) + fx_mul(c2, xy2) + fx_mul(c3, clip47(r2 + 2 * x2)));
            uy = clip47(fx_mul(ny, kr) + fx_mul(c2, clip47(r2 + 2 * y2)) + fx_mul(c3, xy2));
        end else begin
            t = clip47(fx_mul(c2, r2) + k2);
            t = clip47(fx_mul(t, r2) + k1);
            kr = clip47((64'sd1 <<< 28) + fx_mul(t, r2));
            ux = fx_mul(nx, kr);
            uy = fx_mul(ny, kr);
        end
        p.u = 32'(sat_32(fx_mul(ux, longint'({32'd0, coeff_regs[5][31:0]}))
                         + longint'({32'd0, coeff_regs[7][63:32]})));
        p.v = 32'(sat_32(fx_mul(uy, longint'({32'd0, coeff_regs[6][31:0]}))
                         + longint'({32'd0, coeff_regs[7][31:0]})));
        return p;
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                if (i == REG_FOCAL_X || i == REG_FOCAL_Y) coeff_regs[i] <= 64'(FOCAL_RESET);
                else coeff_regs[i] <= '0;
            end
            pixel_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                coeff_regs[cfg_index] <= (cfg_index == REG_PRINCIPAL) ? cfg_wdata
                                         : {32'd0, cfg_wdata[31:0]};
            end
            if (s_tvalid && s_tready) pixel_queue.push_back(project_point(s_tdata));
            if (m_tvalid && m_tready) begin
                if (pixel_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected transaction %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want.u !== m_tdata[31:0] || want.v !== m_tdata[63:32]
                            || want.inv !== m_tuser) begin
                        if (fail_count < 10)
                            $display("mismatch: exp u=%h v=%h inv=%b got u=%h v=%h inv=%b",
                                     want.u, want.v, want.inv,
                                     m_tdata[31:0], m_tdata[63:32], m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/lens_distort_and_project_tb.sv
// Testbench top for lens_distort_and_project: reset, register phases, directed and
// random points with bursty sender and stalling receiver. Needs the checker and ldp_pkg.
module lens_distort_and_project_tb;
    import ldp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    bit          hold_off = 1'b0;   // long receiver stall request
    int          idle_cycles = 0;

    always #4 aclk = ~aclk;

    lens_distort_and_project DUT (.*);
    lens_distort_and_project_checker u_checker (.*);

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) m_tready <= 1'b0;
        else if (r < 30) m_tready <= 1'b0;
        else m_tready <= 1'b1;
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for all results, then idle on for safety
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // offer one point; valid stays high across back-to-back transactions
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    // mostly modest points in front of the camera, some extremes and bad depth
    task automatic random_point();
        logic [31:0] x, y, z;
        int r;
        r = $urandom_range(0, 99);
        x = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        y = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        z = 32'($urandom_range(1 << 15, 16 << 16));
        if (r < 10) begin
            x = $urandom; y = $urandom; z = $urandom;
        end else if (r < 15) begin
            z = $urandom_range(1, 64);
        end else if (r < 20) begin
            z = -32'($urandom_range(0, 1000));
        end
        send_point(x, y, z);
    endtask

    task automatic random_burst(input int count);
        int left;
        left = count;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, 20);
            for (int i = 0; i < len && left > 0; i++) begin
                random_point();
                left--;
            end
            if ($urandom_range(0, 3) != 0) gap();
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic random_coeffs(input bit five_term);
        for (int i = 0; i < 4; i++)
            write_reg(3'(i), 64'($signed($urandom_range(0, 1 << 28)) - (1 << 27)));
        write_reg(REG_COEFF_4, five_term ? 64'($urandom_range(1, 1 << 26)) : 64'd0);
        write_reg(REG_FOCAL_X, 64'($urandom_range(100 << 16, 2000 << 16)));
        write_reg(REG_FOCAL_Y, 64'($urandom_range(100 << 16, 2000 << 16)));
        write_reg(REG_PRINCIPAL, {32'($urandom_range(0, 1000 << 16)),
                                  32'($urandom_range(0, 1000 << 16))});
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, field extremes, bad depth
        send_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        send_point(32'h1234_5678, 32'h1, 32'h0);
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'hffff_ffff);
        s_tvalid <= 1'b0;
        drain();

        // extreme coefficients, five-term mode, saturated projection
        write_reg(REG_COEFF_0, 64'h7fff_ffff);
        write_reg(REG_COEFF_1, 64'h8000_0000);
        write_reg(REG_COEFF_2, 64'h7fff_ffff);
        write_reg(REG_COEFF_3, 64'h8000_0000);
        write_reg(REG_COEFF_4, 64'h8000_0000);
        write_reg(REG_FOCAL_X, 64'hffff_ffff);
        write_reg(REG_FOCAL_Y, 64'h0);
        write_reg(REG_PRINCIPAL, 64'hffff_ffff_ffff_ffff);
        send_point(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000);
        send_point(32'h0000_8000, 32'h0000_4000, 32'h0001_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
        s_tvalid <= 1'b0;
        drain();

        // three-term mode with extreme k3 in coeff_2
        write_reg(REG_COEFF_4, 64'h0);
        write_reg(REG_FOCAL_Y, 64'hffff_ffff);
        write_reg(REG_PRINCIPAL, 64'h0);
        send_point(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000);
        send_point(32'h0000_8000, 32'hffff_c000, 32'h0001_0000);
        send_point(32'h0100_0000, 32'h0000_0000, 32'h0001_0000);
        s_tvalid <= 1'b0;
        drain();

        // random phases alternating model, ~900 points
        for (int ph = 0; ph < 6; ph++) begin
            random_coeffs(ph[0]);
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    random_burst(150);
                join
            end else begin
                random_burst(150);
            end
            // sender pauses until every result is back
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/ldp_pkg.sv
design/ldp_qmul.sv
design/lens_distort_and_project.sv
tb/lens_distort_and_project_checker.sv
tb/lens_distort_and_project_tb.sv
